// File: src/plsm_pkg.sv
// ----------------------------------------------------------------------------
// plsm_pkg
// Shared types and constants of the posting list set merge unit.
// ----------------------------------------------------------------------------
package plsm_pkg;

	localparam int MAX_IDS   = 1024;
	localparam int ID_BITS   = 20;
	localparam int ADDR_BITS = $clog2(MAX_IDS);
	localparam int CNT_BITS  = ADDR_BITS + 1;
	localparam int TOT_BITS  = 21;
	localparam int POS_BITS  = 20;

	localparam logic [2:0] CMD_PUSH      = 3'd0;
	localparam logic [2:0] CMD_END_LIST  = 3'd1;
	localparam logic [2:0] CMD_END_GROUP = 3'd2;
	localparam logic [2:0] CMD_READ      = 3'd3;
	localparam logic [2:0] CMD_CLEAR     = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

	typedef logic [ID_BITS-1:0]   id_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef struct packed {
		logic [2:0]          cmd;
		id_t                 doc_id;
		logic [POS_BITS-1:0] read_position;
	} req_t;

	typedef struct packed {
		id_t                 member_id;
		logic [TOT_BITS-1:0] set_count;
		logic [1:0]          status;
		logic                all_docs;
	} rsp_t;

endpackage

// File: src/plsm_if.sv
// ----------------------------------------------------------------------------
// plsm_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface plsm_req_if;
	logic            valid;
	logic            ready;
	plsm_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface plsm_rsp_if;
	logic            valid;
	logic            ready;
	plsm_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface plsm_cfg_if;
	logic        valid;
	logic        ready;
	logic [20:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/posting_list_set_merge_unit.sv
// ----------------------------------------------------------------------------
// posting_list_set_merge_unit
// Sorted union and intersection of posting lists held in four RAMs.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | cmd, doc_id, read_position
// rsp     | out | member_id, set_count, status, all_docs
// cfg     | in  | doc_total
//
// Push, clear, unused commands and a read with no candidate set are answered
// from idle directly; a read of the candidate set passes through S_READ (RAM read).
// end_list walks both lists, one merged id per cycle, then copies the result
// back from scratch into the group accumulator. end_group copies or intersects
// the accumulator into the candidate set.
// A new request is taken only when the response register is free.
// arst_n clears all counts and flags; the RAM contents stay as they are.
// ----------------------------------------------------------------------------
module posting_list_set_merge_unit (
	input  logic clk,
	input  logic arst_n,
	plsm_req_if.sink   req,
	plsm_rsp_if.source rsp,
	plsm_cfg_if.sink   cfg
);
	import plsm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_MERGE = 3'd2;
	localparam logic [2:0] S_COPY  = 3'd3;
	localparam logic [2:0] S_ISECT = 3'd4;
	localparam logic [2:0] S_CCOPY = 3'd5;

	logic [2:0] state_q;
	logic [TOT_BITS-1:0] doc_total_q;
	cnt_t inc_cnt_q, grp_cnt_q, cand_cnt_q;
	logic cand_valid_q;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic [POS_BITS-1:0] pos_q;

	// walk pointers: a over first list, b over second, k output
	cnt_t a_q, b_q, k_q;
	logic pend_q;     // RAM read data for (a_q, b_q) arrives this cycle
	logic over_q;

	// Memories: incoming, group accumulator, scratch, candidate
	logic  inc_we, grp_we, scr_we, cnd_we;
	addr_t inc_wa, grp_wa, scr_wa, cnd_wa;
	id_t   inc_wd, grp_wd, scr_wd, cnd_wd;
	addr_t inc_ra, grp_ra, scr_ra, cnd_ra;
	id_t   inc_rd, grp_rd, scr_rd, cnd_rd;

	plsm_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_IDS)) u_inc (.clk, .we(inc_we), .waddr(inc_wa),
		.wdata(inc_wd), .raddr(inc_ra), .rdata(inc_rd));
	plsm_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_IDS)) u_grp (.clk, .we(grp_we), .waddr(grp_wa),
		.wdata(grp_wd), .raddr(grp_ra), .rdata(grp_rd));
	plsm_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_IDS)) u_scr (.clk, .we(scr_we), .waddr(scr_wa),
		.wdata(scr_wd), .raddr(scr_ra), .rdata(scr_rd));
	plsm_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_IDS)) u_cnd (.clk, .we(cnd_we), .waddr(cnd_wa),
		.wdata(cnd_wd), .raddr(cnd_ra), .rdata(cnd_rd));

	logic req_fire, rsp_fire;
	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = rsp.valid && rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign cfg.ready = 1'b1;

	// walk decisions
	logic a_has, b_has, a_take, b_take;
	id_t  a_val, b_val;
	always_comb begin
		a_val  = (state_q == S_ISECT) ? cnd_rd : grp_rd;
		b_val  = (state_q == S_ISECT) ? grp_rd : inc_rd;
		a_has  = (state_q == S_ISECT) ? (a_q < cand_cnt_q) : (a_q < grp_cnt_q);
		b_has  = (state_q == S_ISECT) ? (b_q < grp_cnt_q)  : (b_q < inc_cnt_q);
		a_take = a_has && (!b_has || a_val <= b_val);
		b_take = b_has && (!a_has || b_val <= a_val);
	end

	cnt_t a_nx, b_nx;
	assign a_nx = a_q + cnt_t'(a_take);
	assign b_nx = b_q + cnt_t'(b_take);

	always_comb begin
		inc_we = 1'b0; inc_wa = inc_cnt_q[ADDR_BITS-1:0]; inc_wd = req.data.doc_id;
		grp_we = 1'b0; grp_wa = k_q[ADDR_BITS-1:0];       grp_wd = scr_rd;
		scr_we = 1'b0; scr_wa = k_q[ADDR_BITS-1:0];       scr_wd = a_take ? a_val : b_val;
		cnd_we = 1'b0; cnd_wa = k_q[ADDR_BITS-1:0];       cnd_wd = a_val;
		inc_ra = b_q[ADDR_BITS-1:0];
		grp_ra = (state_q == S_ISECT) ? b_q[ADDR_BITS-1:0] : a_q[ADDR_BITS-1:0];
		scr_ra = a_q[ADDR_BITS-1:0];
		cnd_ra = (state_q == S_READ) ? pos_q[ADDR_BITS-1:0] : a_q[ADDR_BITS-1:0];
		case (state_q)
			S_IDLE: begin
				inc_we = req_fire && req.data.cmd == CMD_PUSH && inc_cnt_q < cnt_t'(MAX_IDS);
				cnd_ra = req.data.read_position[ADDR_BITS-1:0];
				inc_ra = '0; grp_ra = '0; scr_ra = '0;
			end
			S_MERGE: begin
				scr_we = pend_q && (a_has || b_has) && k_q < cnt_t'(MAX_IDS);
				if (pend_q) begin
					inc_ra = b_nx[ADDR_BITS-1:0];
					grp_ra = a_nx[ADDR_BITS-1:0];
				end
			end
			S_COPY: begin
				grp_we = pend_q && a_q < k_q;
				grp_wa = a_q[ADDR_BITS-1:0];
				scr_ra = pend_q ? a_q[ADDR_BITS-1:0] + 1'b1 : a_q[ADDR_BITS-1:0];
			end
			S_ISECT: begin
				cnd_we = pend_q && a_has && b_has && a_val == b_val;
				if (pend_q) begin
					cnd_ra = a_nx[ADDR_BITS-1:0];
					grp_ra = b_nx[ADDR_BITS-1:0];
				end
			end
			S_CCOPY: begin
				cnd_we = pend_q && a_q < grp_cnt_q;
				cnd_wa = a_q[ADDR_BITS-1:0];
				cnd_wd = grp_rd;
				grp_ra = pend_q ? a_q[ADDR_BITS-1:0] + 1'b1 : a_q[ADDR_BITS-1:0];
			end
			default: ;
		endcase
	end

	function automatic rsp_t mk_rsp(input logic cv, input cnt_t cc, input logic [TOT_BITS-1:0] dt,
			input id_t m, input logic [1:0] st);
		rsp_t r;
		r.member_id = m;
		r.set_count = cv ? TOT_BITS'(cc) : dt;
		r.status    = st;
		r.all_docs  = !cv;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; doc_total_q <= '0;
			inc_cnt_q <= '0; grp_cnt_q <= '0; cand_cnt_q <= '0; cand_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0; a_q <= '0; b_q <= '0; k_q <= '0;
			pend_q <= 1'b0; over_q <= 1'b0;
		end else begin
			if (cfg.valid) doc_total_q <= cfg.data;
			if (rsp_fire) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req_fire) begin
					a_q <= '0; b_q <= '0; k_q <= '0; pend_q <= 1'b0; over_q <= 1'b0;
					pos_q <= req.data.read_position;
					case (req.data.cmd)
						CMD_PUSH: begin
							rsp_valid_q <= 1'b1;
							rsp_q <= mk_rsp(cand_valid_q, cand_cnt_q, doc_total_q, '0,
								inc_cnt_q < cnt_t'(MAX_IDS) ? ST_OK : ST_OVERFLOW);
							if (inc_cnt_q < cnt_t'(MAX_IDS)) inc_cnt_q <= inc_cnt_q + 1'b1;
						end
						CMD_END_LIST:  state_q <= S_MERGE;
						CMD_END_GROUP: state_q <= cand_valid_q ? S_ISECT : S_CCOPY;
						CMD_READ: begin
							if (cand_valid_q) state_q <= S_READ;
							else begin
								rsp_valid_q <= 1'b1;
								rsp_q <= (TOT_BITS'(req.data.read_position) < doc_total_q)
									? mk_rsp(1'b0, '0, doc_total_q, req.data.read_position, ST_OK)
									: mk_rsp(1'b0, '0, doc_total_q, '0, ST_RANGE);
							end
						end
						CMD_CLEAR: begin
							inc_cnt_q <= '0; grp_cnt_q <= '0; cand_cnt_q <= '0;
							cand_valid_q <= 1'b0; rsp_valid_q <= 1'b1;
							rsp_q <= mk_rsp(1'b0, '0, doc_total_q, '0, ST_OK);
						end
						default: begin
							rsp_valid_q <= 1'b1;
							rsp_q <= mk_rsp(cand_valid_q, cand_cnt_q, doc_total_q, '0, ST_OK);
						end
					endcase
				end
				S_READ: begin
					state_q <= S_IDLE; rsp_valid_q <= 1'b1;
					rsp_q <= (pos_q < POS_BITS'(cand_cnt_q))
						? mk_rsp(1'b1, cand_cnt_q, doc_total_q, cnd_rd, ST_OK)
						: mk_rsp(1'b1, cand_cnt_q, doc_total_q, '0, ST_RANGE);
				end
				S_MERGE: begin
					pend_q <= 1'b1;
					if (pend_q) begin
						if (!a_has && !b_has) begin
							state_q <= S_COPY; a_q <= '0; pend_q <= 1'b0;
						end else begin
							a_q <= a_nx; b_q <= b_nx;
							if (k_q < cnt_t'(MAX_IDS)) k_q <= k_q + 1'b1;
							else over_q <= 1'b1;
						end
					end
				end
				S_COPY: begin
					pend_q <= 1'b1;
					if (pend_q) begin
						if (a_q >= k_q) begin
							state_q <= S_IDLE; grp_cnt_q <= k_q; inc_cnt_q <= '0;
							rsp_valid_q <= 1'b1;
							rsp_q <= mk_rsp(cand_valid_q, cand_cnt_q, doc_total_q, '0,
								over_q ? ST_OVERFLOW : ST_OK);
						end else a_q <= a_q + 1'b1;
					end
				end
				S_ISECT: begin
					pend_q <= 1'b1;
					if (pend_q) begin
						if (!a_has || !b_has) begin
							state_q <= S_IDLE; cand_cnt_q <= k_q; grp_cnt_q <= '0;
							rsp_valid_q <= 1'b1;
							rsp_q <= mk_rsp(1'b1, k_q, doc_total_q, '0, ST_OK);
						end else begin
							a_q <= a_nx; b_q <= b_nx;
							if (a_val == b_val) k_q <= k_q + 1'b1;
						end
					end
				end
				S_CCOPY: begin
					pend_q <= 1'b1;
					if (pend_q) begin
						if (a_q >= grp_cnt_q) begin
							state_q <= S_IDLE; cand_cnt_q <= grp_cnt_q; grp_cnt_q <= '0;
							cand_valid_q <= 1'b1; rsp_valid_q <= 1'b1;
							rsp_q <= mk_rsp(1'b1, grp_cnt_q, doc_total_q, '0, ST_OK);
						end else a_q <= a_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// In the copy states the entry at a_q arrives from the RAM while pend_q is
	// high and is written back at a_q in that cycle, while the read moves on to
	// a_q+1; the first cycle of the state only starts the read of entry 0.

	assert property (@(posedge clk) disable iff (!arst_n) rsp_valid_q && !rsp.ready |=> rsp_valid_q)
		else $error("response lost");
	assert property (@(posedge clk) disable iff (!arst_n) inc_cnt_q <= cnt_t'(MAX_IDS))
		else $error("incoming count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n) req_fire |-> !rsp_valid_q)
		else $error("request taken while response pending");
	assert property (@(posedge clk) disable iff (!arst_n) state_q != S_IDLE |-> !req.ready)
		else $error("ready while walking");
endmodule

// File: src/plsm_ram.sv
// ----------------------------------------------------------------------------
// plsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the posting list set merge unit. A directed table
// covers resets, extremes, overflow, range errors and clear; random query
// sequences of pushes, list ends, group ends, reads, clears and random commands
// follow, each response checked against a behavioural model of the candidate set.
// ----------------------------------------------------------------------------
module testbench;
	import plsm_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd6;
	localparam int LAT = 4200;

	typedef struct {
		logic [2:0] cmd;
		int unsigned id;
		int unsigned pos;
		bit chk;
		rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	plsm_req_if req ();
	plsm_rsp_if rsp ();
	plsm_cfg_if cfg ();

	posting_list_set_merge_unit DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	always #2 clk = ~clk;

	// Model state of the query combiner.
	logic [TOT_BITS-1:0] total_docs;
	id_t incoming_ids[$];
	id_t group_ids[$];
	id_t cand_ids[$];
	bit cand_ready;
	rsp_t pending_rsp[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int n_sent = 0;

	task automatic report(input string what, input rsp_t got, input rsp_t want);
		$display("mismatch %s: got %0h/%0h/%0h/%0h want %0h/%0h/%0h/%0h", what,
			got.member_id, got.set_count, got.status, got.all_docs,
			want.member_id, want.set_count, want.status, want.all_docs);
		errors++;
	endtask

	function automatic rsp_t predict_query(input logic [2:0] cmd, input id_t id,
			input logic [POS_BITS-1:0] pos);
		rsp_t r;
		id_t merged[$];
		id_t kept[$];
		int a, b;
		id_t v;
		r = '0;
		case (cmd)
		CMD_PUSH: begin
			if (incoming_ids.size() < MAX_IDS) incoming_ids.push_back(id);
			else r.status = ST_OVERFLOW;
		end
		CMD_END_LIST: begin
			a = 0;
			b = 0;
			while (a < group_ids.size() || b < incoming_ids.size()) begin
				if (a < group_ids.size() && b < incoming_ids.size()) begin
					if (group_ids[a] == incoming_ids[b]) begin
						v = group_ids[a]; a++; b++;
					end else if (group_ids[a] < incoming_ids[b]) begin
						v = group_ids[a]; a++;
					end else begin
						v = incoming_ids[b]; b++;
					end
				end else if (a < group_ids.size()) begin
					v = group_ids[a]; a++;
				end else begin
					v = incoming_ids[b]; b++;
				end
				if (merged.size() < MAX_IDS) merged.push_back(v);
				else r.status = ST_OVERFLOW;
			end
			group_ids = merged;
			incoming_ids.delete();
		end
		CMD_END_GROUP: begin
			if (!cand_ready) cand_ids = group_ids;
			else begin
				a = 0;
				b = 0;
				while (a < cand_ids.size() && b < group_ids.size()) begin
					if (cand_ids[a] == group_ids[b]) begin
						kept.push_back(cand_ids[a]); a++; b++;
					end else if (cand_ids[a] < group_ids[b]) a++;
					else b++;
				end
				cand_ids = kept;
			end
			cand_ready = 1;
			group_ids.delete();
		end
		CMD_READ: begin
			if (cand_ready) begin
				if (pos < cand_ids.size()) r.member_id = cand_ids[pos];
				else r.status = ST_RANGE;
			end else begin
				if (pos < total_docs) r.member_id = pos;
				else r.status = ST_RANGE;
			end
		end
		CMD_CLEAR: begin
			incoming_ids.delete();
			group_ids.delete();
			cand_ids.delete();
			cand_ready = 0;
		end
		default: ;
		endcase
		r.set_count = cand_ready ? TOT_BITS'(cand_ids.size()) : total_docs;
		r.all_docs = !cand_ready;
		return r;
	endfunction

	// The request stays valid between back-to-back calls; it drops only while idling or draining.
	task automatic send_query(input logic [2:0] cmd, input int unsigned id,
			input int unsigned pos, input bit chk, input rsp_t want);
		rsp_t p;
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= '{cmd: cmd, doc_id: id[ID_BITS-1:0], read_position: pos[POS_BITS-1:0]};
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		p = predict_query(cmd, id[ID_BITS-1:0], pos[POS_BITS-1:0]);
		if (chk && p != want) begin
			report("table row", p, want);
		end
		pending_rsp.push_back(p);
		n_sent++;
	endtask

	task automatic drain();
		int n;
		n = 0;
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		while (n < LAT) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_total(input int unsigned v);
		cfg.valid <= 1'b1;
		cfg.data <= v[TOT_BITS-1:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		total_docs = v[TOT_BITS-1:0];
		cfg.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		rsp_t e;
		if (rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected response", rsp.data, '0);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.data !== e) report("response", rsp.data, e);
			end
		end
		rsp.ready <= ($urandom_range(99) >= recv_idle);
	end

	// One group: a few mostly sorted lists (some pushes carry a random id), mostly small, sometimes large.
	task automatic random_group();
		int lists, len, step;
		int unsigned id;
		lists = $urandom_range(1, 3);
		for (int l = 0; l < lists; l++) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
			step = ($urandom_range(3) == 0) ? $urandom_range(1, 40000) : $urandom_range(1, 6);
			id = ($urandom_range(3) == 0) ? $urandom_range(0, 1048575 - 120 * 40000 / 40)
				: $urandom_range(0, 20);
			for (int k = 0; k < len; k++) begin
				send_query(CMD_PUSH, $urandom_range(9) == 0 ? $urandom() : id, 0, 0, '0);
				id = (id + step) & 20'hFFFFF;
			end
			send_query(CMD_END_LIST, 0, 0, 0, '0);
		end
		send_query(CMD_END_GROUP, 0, 0, 0, '0);
	endtask

	initial begin
		row_t tbl[$];
		int sent;
		int pick;
		req.valid = 1'b0;
		req.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		rsp.ready = 1'b0;
		total_docs = '0;
		cand_ready = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tbl = '{
			'{CMD_READ, 0, 0, 1, '{0, 0, ST_RANGE, 1}},
			'{CMD_UNUSED, 5, 5, 1, '{0, 0, ST_OK, 1}},
			'{3'd7, 0, 0, 1, '{0, 0, ST_OK, 1}},
			'{3'd5, 0, 0, 1, '{0, 0, ST_OK, 1}}
		};
		foreach (tbl[i]) send_query(tbl[i].cmd, tbl[i].id, tbl[i].pos, tbl[i].chk, tbl[i].want);
		drain();
		write_total(21'h100000);
		tbl = '{
			'{CMD_READ, 0, 20'hFFFFF, 1, '{20'hFFFFF, 21'h100000, ST_OK, 1}},
			'{CMD_READ, 0, 0, 1, '{0, 21'h100000, ST_OK, 1}},
			'{CMD_PUSH, 0, 0, 1, '{0, 21'h100000, ST_OK, 1}},
			'{CMD_PUSH, 20'hFFFFF, 0, 1, '{0, 21'h100000, ST_OK, 1}},
			'{CMD_END_LIST, 0, 0, 0, '0},
			'{CMD_PUSH, 20'hFFFFF, 0, 0, '0},
			'{CMD_PUSH, 7, 0, 0, '0},
			'{CMD_END_LIST, 0, 0, 0, '0},
			'{CMD_PUSH, 3, 0, 0, '0},
			'{CMD_END_GROUP, 0, 0, 0, '0},
			'{CMD_READ, 0, 2, 0, '0},
			'{CMD_READ, 0, 3, 1, '{0, 3, ST_RANGE, 0}},
			'{CMD_END_LIST, 0, 0, 0, '0},
			'{CMD_END_GROUP, 0, 0, 0, '0},
			'{CMD_END_GROUP, 0, 0, 1, '{0, 0, ST_OK, 0}},
			'{CMD_READ, 0, 0, 1, '{0, 0, ST_RANGE, 0}},
			'{CMD_CLEAR, 0, 0, 1, '{0, 21'h100000, ST_OK, 1}}
		};
		foreach (tbl[i]) send_query(tbl[i].cmd, tbl[i].id, tbl[i].pos, tbl[i].chk, tbl[i].want);
		// Fill the incoming list past its depth, then overflow the union.
		for (int k = 0; k <= MAX_IDS; k++) send_query(CMD_PUSH, 2 * k, 0, 0, '0);
		send_query(CMD_END_LIST, 0, 0, 0, '0);
		for (int k = 0; k < 8; k++) send_query(CMD_PUSH, 2 * k + 1, 0, 0, '0);
		send_query(CMD_END_LIST, 0, 0, 0, '0);
		send_query(CMD_END_GROUP, 0, 0, 0, '0);
		send_query(CMD_READ, 0, MAX_IDS - 1, 0, '0);
		send_query(CMD_CLEAR, 0, 0, 0, '0);
		drain();
		write_total(0);

		sent = n_sent;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 35 : (ph == 1) ? 81 : 0;
			recv_idle = (ph == 0) ? 81 : (ph == 1) ? 35 : 0;
			while (n_sent < sent + 250 * (ph + 1)) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					random_group();
				end else if (pick < 80) begin
					send_query(CMD_READ, 0, $urandom_range(3) == 0 ? $urandom()
						: $urandom_range(0, 40), 0, '0);
				end else if (pick < 85) begin
					send_query(CMD_CLEAR, 0, 0, 0, '0);
				end else begin
					send_query(3'($urandom_range(7)), $urandom(), $urandom(), 0, '0);
				end
			end
			drain();
			write_total(ph == 0 ? 21'h1FFFFF : ph == 1 ? $urandom_range(1, 64) : 0);
		end
		drain();
		if (errors == 0) $display("[posting_list_set_merge_unit] OK");
		else $display("[posting_list_set_merge_unit] ERROR");
		$finish;
	end

	initial begin
		#40000000;
		$display("[posting_list_set_merge_unit] ERROR");
		$finish;
	end
endmodule
